/* rtl/plist_pkg.sv */
// shared types, codes and defaults for the positional list
`default_nettype none

package plist_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int ENTRY_BITS_DEF = 16;

    // widths of the port fields
    localparam int CMD_W    = 1;
    localparam int WHERE_W  = 2;
    localparam int POS_W    = 7;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [WHERE_W-1:0] {
        WHERE_HEAD = 2'd0,
        WHERE_TAIL = 2'd1,
        WHERE_POS  = 2'd2
    } where_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // per-cycle shift command broadcast to the row of cells
    typedef struct packed {
        logic ins;
        logic rem;
    } plist_ctl_t;

    // outcome of decoding one command against the current count
    typedef struct packed {
        status_t status;
        logic    ins;
        logic    rem;
    } plist_dec_t;

endpackage

`default_nettype wire

/* rtl/plist_cell.sv */
// one list slot: holds an entry and shifts toward head or tail
`default_nettype none

module plist_cell #(
    parameter int ENTRY_BITS = plist_pkg::ENTRY_BITS_DEF,
    parameter int IDX_W      = 7,
    parameter int INDEX      = 0
) (
    input  wire                     clk,
    input  wire plist_pkg::plist_ctl_t ctl,
    input  wire  [IDX_W-1:0]        pos,
    input  wire  [ENTRY_BITS-1:0]   entry,
    input  wire  [ENTRY_BITS-1:0]   left_data,
    input  wire  [ENTRY_BITS-1:0]   right_data,
    output logic [ENTRY_BITS-1:0]   data,
    output logic [ENTRY_BITS-1:0]   pick
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ENTRY_BITS-1:0] data_reg;
    logic [ENTRY_BITS-1:0] data_next;
    logic                  at_pos;
    logic                  past_pos;

    assign at_pos   = (MY_IDX == pos);
    assign past_pos = (MY_IDX > pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (at_pos)
                data_next = entry;
            else if (past_pos)
                data_next = left_data;
        end
        else if (ctl.rem)
        begin
            if (at_pos || past_pos)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // only the addressed slot puts its word on the pick bus
    assign pick = at_pos ? data_reg : '0;

endmodule

`default_nettype wire

/* rtl/plist_decode.sv */
// command decode: range and full checks, target position
`default_nettype none

module plist_decode #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire  [plist_pkg::CMD_W-1:0]   cmd,
    input  wire  [plist_pkg::WHERE_W-1:0] where,
    input  wire  [plist_pkg::POS_W-1:0]   position,
    input  wire  [CNT_W-1:0]              count,
    output plist_pkg::plist_dec_t         dec,
    output logic [CNT_W-1:0]              pos
);

    localparam int CMP_W = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             in_range;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count);

    always_comb
    begin
        dec.status = plist_pkg::ST_RANGE;
        dec.ins    = 1'b0;
        dec.rem    = 1'b0;
        pos        = '0;
        in_range   = 1'b0;
        if (plist_pkg::cmd_t'(cmd) == plist_pkg::CMD_INSERT)
        begin
            case (plist_pkg::where_t'(where))
                plist_pkg::WHERE_HEAD:
                begin
                    in_range = 1'b1;
                    pos      = '0;
                end
                plist_pkg::WHERE_TAIL:
                begin
                    in_range = 1'b1;
                    pos      = count;
                end
                plist_pkg::WHERE_POS:
                begin
                    in_range = (pos_ext <= cnt_ext);
                    pos      = CNT_W'(position);
                end
                default:
                begin
                    in_range = 1'b0;
                end
            endcase
            // range check wins over the full check
            if (in_range)
            begin
                if (count == FULL_CNT)
                    dec.status = plist_pkg::ST_FULL;
                else
                begin
                    dec.status = plist_pkg::ST_DONE;
                    dec.ins    = 1'b1;
                end
            end
        end
        else if (count != '0)
        begin
            case (plist_pkg::where_t'(where))
                plist_pkg::WHERE_HEAD:
                begin
                    in_range = 1'b1;
                    pos      = '0;
                end
                plist_pkg::WHERE_TAIL:
                begin
                    in_range = 1'b1;
                    pos      = count - CNT_W'(1);
                end
                plist_pkg::WHERE_POS:
                begin
                    in_range = (pos_ext < cnt_ext);
                    pos      = CNT_W'(position);
                end
                default:
                begin
                    in_range = 1'b0;
                end
            endcase
            if (in_range)
            begin
                dec.status = plist_pkg::ST_DONE;
                dec.rem    = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/positional_list_insert_remove.sv */
// a result word is registered and appears in the cycle after its command word is accepted
// throughput: one command per cycle while in_stall is low; every cell at or past the target shifts in the same cycle
// a held result stalls input only while out_stall keeps the output register full
// reset clears the entry count and output valid; cell contents are not cleared
// and are read only below the count
`default_nettype none

module positional_list_insert_remove #(
    parameter int CAPACITY   = plist_pkg::CAPACITY_DEF,
    parameter int ENTRY_BITS = plist_pkg::ENTRY_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire  [plist_pkg::CMD_W-1:0]       cmd,
    input  wire  [plist_pkg::WHERE_W-1:0]     where,
    input  wire  [plist_pkg::POS_W-1:0]       position,
    input  wire  [plist_pkg::HANDLE_W-1:0]    entry_in,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [plist_pkg::STATUS_W-1:0]    status,
    output logic [plist_pkg::HANDLE_W-1:0]    removed_entry,
    output logic [plist_pkg::COUNT_W-1:0]     count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                 accept;
    plist_pkg::plist_dec_t dec;
    plist_pkg::plist_ctl_t ctl;
    logic [CNT_W-1:0]     pos;
    logic [ENTRY_BITS-1:0] entry;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [plist_pkg::STATUS_W-1:0]    status_reg;
    logic [plist_pkg::HANDLE_W-1:0]    removed_reg;
    logic [plist_pkg::COUNT_W-1:0]     count_out_reg;

    logic [ENTRY_BITS-1:0] cell_data [CAPACITY];
    logic [ENTRY_BITS-1:0] cell_pick [CAPACITY];
    logic [CAPACITY-1:0]   pick_col  [ENTRY_BITS];
    logic [ENTRY_BITS-1:0] pick_word;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign entry    = ENTRY_BITS'(entry_in);

    plist_decode #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_decode (
        .cmd      (cmd),
        .where    (where),
        .position (position),
        .count    (count_reg),
        .dec      (dec),
        .pos      (pos)
    );

    assign ctl.ins = accept & dec.ins;
    assign ctl.rem = accept & dec.rem;

    genvar gi, gb;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ENTRY_BITS-1:0] left_data;
            logic [ENTRY_BITS-1:0] right_data;

            if (gi == 0)
            begin : g_first
                assign left_data = '0;
            end
            else
            begin : g_mid_l
                assign left_data = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_data = '0;
            end
            else
            begin : g_mid_r
                assign right_data = cell_data[gi+1];
            end

            plist_cell #(
                .ENTRY_BITS (ENTRY_BITS),
                .IDX_W      (CNT_W),
                .INDEX      (gi)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos        (pos),
                .entry      (entry),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (cell_data[gi]),
                .pick       (cell_pick[gi])
            );

            for (gb = 0; gb < ENTRY_BITS; gb++)
            begin : g_col
                assign pick_col[gb][gi] = cell_pick[gi][gb];
            end
        end

        // one-hot pick bus: at most one cell drives nonzero
        for (gb = 0; gb < ENTRY_BITS; gb++)
        begin : g_pick
            assign pick_word[gb] = |pick_col[gb];
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctl.rem)
            count_next = count_reg - CNT_W'(1);
    end

    assign out_valid_next = accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= dec.status;
            removed_reg   <= dec.rem ? plist_pkg::HANDLE_W'(pick_word) : '0;
            count_out_reg <= plist_pkg::COUNT_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_entry = removed_reg;
    assign count         = count_out_reg;

endmodule

`default_nettype wire

/* rtl/plist_check.sv */
// port-level checks for the positional list, bound to the top level
`default_nettype none

module plist_check (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            in_valid,
    input wire                            in_stall,
    input wire                            out_valid,
    input wire                            out_stall,
    input wire [plist_pkg::STATUS_W-1:0]  status,
    input wire [plist_pkg::HANDLE_W-1:0]  removed_entry,
    input wire [plist_pkg::COUNT_W-1:0]   count
);

    // every accepted command word yields a result word next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("no result after accepted command");

    // input is held back only while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    // failed commands carry no removed entry
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != plist_pkg::ST_DONE) |-> (removed_entry == '0))
        else $error("failed command returned an entry");

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(status) && $stable(removed_entry) && $stable(count)))
        else $error("stalled result changed");

endmodule

bind positional_list_insert_remove plist_check u_plist_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_entry (removed_entry),
    .count         (count)
);

`default_nettype wire

/* tb/sv/tb_positional_list_insert_remove.sv */
// self-checking testbench for the positional list: edge cases, full list, random walk
`default_nettype none

module tb_positional_list_insert_remove;

    localparam int LIST_DEPTH   = plist_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 5;

    // where code that the block must reject
    localparam logic [plist_pkg::WHERE_W-1:0] WHERE_UNUSED = 2'd3;

    typedef struct {
        plist_pkg::status_t                status;
        logic [plist_pkg::HANDLE_W-1:0]    removed_entry;
        logic [plist_pkg::COUNT_W-1:0]     count;
    } list_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [plist_pkg::CMD_W-1:0]       cmd;
    logic [plist_pkg::WHERE_W-1:0]     where;
    logic [plist_pkg::POS_W-1:0]       position;
    logic [plist_pkg::HANDLE_W-1:0]    entry_in;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [plist_pkg::STATUS_W-1:0]    status;
    logic [plist_pkg::HANDLE_W-1:0]    removed_entry;
    logic [plist_pkg::COUNT_W-1:0]     count;

    logic [plist_pkg::HANDLE_W-1:0]    shadow_list[$];
    list_result_t                      pending_results[$];
    int                                err_count = 0;
    bit                                idle_on = 1'b0;
    int                                stall_left = 0;
    int                                cycle_count = 0;

    positional_list_insert_remove u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .where         (where),
        .position      (position),
        .entry_in      (entry_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_entry (removed_entry),
        .count         (count)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // applies one command word to the shadow list and returns the expected result
    function automatic list_result_t apply_list_cmd(
        input logic [plist_pkg::CMD_W-1:0]    c,
        input logic [plist_pkg::WHERE_W-1:0]  w,
        input logic [plist_pkg::POS_W-1:0]    p,
        input logic [plist_pkg::HANDLE_W-1:0] e
    );
        list_result_t res;
        int           idx;
        res.status        = plist_pkg::ST_DONE;
        res.removed_entry = '0;
        idx               = 0;
        if (c == plist_pkg::CMD_INSERT)
        begin
            case (w)
                plist_pkg::WHERE_HEAD: idx = 0;
                plist_pkg::WHERE_TAIL: idx = shadow_list.size();
                plist_pkg::WHERE_POS:
                begin
                    if (int'(p) > shadow_list.size())
                        res.status = plist_pkg::ST_RANGE;
                    idx = int'(p);
                end
                default: res.status = plist_pkg::ST_RANGE;
            endcase
            // range check wins over the full check
            if (res.status == plist_pkg::ST_DONE && shadow_list.size() >= LIST_DEPTH)
                res.status = plist_pkg::ST_FULL;
            if (res.status == plist_pkg::ST_DONE)
                shadow_list.insert(idx, e);
        end
        else if (shadow_list.size() == 0)
        begin
            res.status = plist_pkg::ST_RANGE;
        end
        else
        begin
            case (w)
                plist_pkg::WHERE_HEAD: idx = 0;
                plist_pkg::WHERE_TAIL: idx = shadow_list.size() - 1;
                plist_pkg::WHERE_POS:
                begin
                    if (int'(p) >= shadow_list.size())
                        res.status = plist_pkg::ST_RANGE;
                    idx = int'(p);
                end
                default: res.status = plist_pkg::ST_RANGE;
            endcase
            if (res.status == plist_pkg::ST_DONE)
            begin
                res.removed_entry = shadow_list[idx];
                shadow_list.delete(idx);
            end
        end
        res.count = plist_pkg::COUNT_W'(shadow_list.size());
        return res;
    endfunction

    task automatic send_word(
        input logic [plist_pkg::CMD_W-1:0]    c,
        input logic [plist_pkg::WHERE_W-1:0]  w,
        input logic [plist_pkg::POS_W-1:0]    p,
        input logic [plist_pkg::HANDLE_W-1:0] e
    );
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd      <= c;
        where    <= w;
        position <= p;
        entry_in <= e;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(apply_list_cmd(c, w, p, e));
    endtask

    task automatic send_random_word(input int insert_pct);
        logic [plist_pkg::CMD_W-1:0]   c;
        logic [plist_pkg::WHERE_W-1:0] w;
        int                            p;
        int                            n;
        int                            r;
        n = shadow_list.size();
        c = ($urandom_range(0, 99) < insert_pct) ? plist_pkg::CMD_INSERT
                                                  : plist_pkg::CMD_REMOVE;
        r = $urandom_range(0, 99);
        if (r < 30)
            w = plist_pkg::WHERE_HEAD;
        else if (r < 55)
            w = plist_pkg::WHERE_TAIL;
        else if (r < 95)
            w = plist_pkg::WHERE_POS;
        else
            w = WHERE_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            if (c == plist_pkg::CMD_INSERT)
                p = $urandom_range(0, n);
            else
                p = (n > 0) ? $urandom_range(0, n - 1) : 0;
        end
        else if (r < 85)
            p = n;
        else if (r < 90)
            p = (n > 0) ? n - 1 : 0;
        else
            p = $urandom_range(0, 127);
        send_word(c, w, p[plist_pkg::POS_W-1:0], plist_pkg::HANDLE_W'($urandom()));
    endtask

    task automatic test_empty_list();
        idle_on = 1'b1;
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_HEAD, 7'd0, 16'h1234);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_TAIL, 7'd0, 16'h0000);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_POS, 7'd0, 16'hFFFF);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_POS, 7'd127, 16'h0000);
        send_word(plist_pkg::CMD_REMOVE, WHERE_UNUSED, 7'd0, 16'h0000);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd1, 16'hBEEF);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd127, 16'hBEEF);
        send_word(plist_pkg::CMD_INSERT, WHERE_UNUSED, 7'd0, 16'hBEEF);
    endtask

    task automatic test_edge_handles();
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_HEAD, 7'd0, 16'hFFFF);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_TAIL, 7'd0, 16'h0000);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd1, 16'hA5A5);
        // position equal to the count appends
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd3, 16'h5A5A);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd5, 16'h7777);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_HEAD, 7'd0, 16'h0001);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_POS, 7'd2, 16'hFFFF);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_POS, 7'd4, 16'h0000);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_POS, 7'd3, 16'h0000);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_TAIL, 7'd0, 16'h0000);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_HEAD, 7'd0, 16'h0000);
        send_word(plist_pkg::CMD_REMOVE, WHERE_UNUSED, 7'd0, 16'h0000);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_HEAD, 7'd0, 16'h0000);
    endtask

    task automatic test_full_list();
        logic [plist_pkg::WHERE_W-1:0] w;
        int                            p;
        int                            r;
        while (shadow_list.size() < LIST_DEPTH)
        begin
            r = $urandom_range(0, 2);
            w = (r == 0) ? plist_pkg::WHERE_HEAD
                         : ((r == 1) ? plist_pkg::WHERE_TAIL : plist_pkg::WHERE_POS);
            p = $urandom_range(0, shadow_list.size());
            send_word(plist_pkg::CMD_INSERT, w, p[plist_pkg::POS_W-1:0],
                      plist_pkg::HANDLE_W'($urandom()));
        end
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_HEAD, 7'd0, 16'h1111);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_TAIL, 7'd0, 16'h2222);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd64, 16'h3333);
        // bad position on a full list reports range, not full
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd65, 16'h4444);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd127, 16'h4444);
        send_word(plist_pkg::CMD_INSERT, WHERE_UNUSED, 7'd0, 16'h5555);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_POS, 7'd64, 16'h0000);
        send_word(plist_pkg::CMD_REMOVE, plist_pkg::WHERE_POS, 7'd63, 16'h0000);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd63, 16'hFFFF);
        send_word(plist_pkg::CMD_INSERT, plist_pkg::WHERE_POS, 7'd0, 16'h6666);
        repeat (LIST_DEPTH / 2)
        begin
            r = $urandom_range(0, 2);
            w = (r == 0) ? plist_pkg::WHERE_HEAD
                         : ((r == 1) ? plist_pkg::WHERE_TAIL : plist_pkg::WHERE_POS);
            p = $urandom_range(0, shadow_list.size() - 1);
            send_word(plist_pkg::CMD_REMOVE, w, p[plist_pkg::POS_W-1:0],
                      plist_pkg::HANDLE_W'($urandom()));
        end
    endtask

    task automatic test_random_walk();
        for (int phase = 0; phase < 14; phase++)
        begin
            // every fourth phase runs flat out on both sides
            idle_on = (phase % 4) != 3;
            repeat (100) send_random_word((phase % 2 == 0) ? 80 : 25);
        end
    endtask

    // receiver stalls: mostly short runs, a few long ones
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(4, 19);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no command pending");
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    err_count++;
                end
                if (removed_entry !== want.removed_entry)
                begin
                    $error("removed_entry: expected %h, got %h", want.removed_entry,
                           removed_entry);
                    err_count++;
                end
                if (count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, count);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = plist_pkg::CMD_INSERT;
        where    = plist_pkg::WHERE_HEAD;
        position = '0;
        entry_in = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_edge_handles();
        test_full_list();
        test_random_walk();
        in_valid <= 1'b0;
        idle_on = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
